[hw/rtl/mfep_pkg.sv]
// ----------------------------------------------------------------------------
// mfep_pkg
// Shared types and constants of the MIDI file event parser.
// ----------------------------------------------------------------------------
package mfep_pkg;

  localparam int VLQ_MAX_BYTES = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = 2;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_CHANNEL = 3'd1,
    KIND_SYSEX   = 3'd2,
    KIND_META    = 3'd3,
    KIND_EOT     = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_HDR_MAG  = 3'd1,
    ERR_HDR_LEN  = 3'd2,
    ERR_FORMAT   = 3'd3,
    ERR_TRK_MAG  = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    PH_HDR, PH_TRK, PH_DELTA, PH_STATUS, PH_FIRST, PH_DATA2, PH_LEN, PH_SKIP,
    PH_DONE, PH_ERR
  } phase_t;

  // A classified byte as it passes from the front part to the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    logic       is_system;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] track;
    logic [34:0] delta;
    logic [39:0] position;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [7:0]  meta_type;
    logic [34:0] length;
    logic [15:0] division;
    logic        format;
  } result_t;

  function automatic logic [7:0] hdr_magic(input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = 8'h4d;
      2'd1: r = 8'h54;
      2'd2: r = 8'h68;
      default: r = 8'h64;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trk_magic(input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = 8'h4d;
      2'd1: r = 8'h54;
      2'd2: r = 8'h72;
      default: r = 8'h6b;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/mfep_front.sv]
// ----------------------------------------------------------------------------
// mfep_front
// Accepts file bytes, classifies them and writes them into a short queue.
// ----------------------------------------------------------------------------
module mfep_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  logic [7:0]          byte_in,
  output mfep_pkg::item_t     item,
  output logic                item_valid,
  input  logic                item_take
);

  mfep_pkg::item_t               mem [mfep_pkg::QUEUE_DEPTH];
  logic [mfep_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [mfep_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [mfep_pkg::QUEUE_AW:0]   fill;
  logic                          push;
  logic                          pop;

  assign stall      = (fill == (mfep_pkg::QUEUE_AW+1)'(mfep_pkg::QUEUE_DEPTH));
  assign push       = valid && !stall;
  assign item_valid = (fill != '0);
  assign pop        = item_valid && item_take;
  assign item       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].data      <= byte_in;
      mem[wr_ptr].is_status <= byte_in[7];
      mem[wr_ptr].is_system <= (byte_in[7:4] == 4'hf);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (mfep_pkg::QUEUE_AW+1)'(push) - (mfep_pkg::QUEUE_AW+1)'(pop);
    end
  end

endmodule

[hw/rtl/mfep_back.sv]
// ----------------------------------------------------------------------------
// mfep_back
// Parse state machine: takes classified bytes and produces result items
// into an output register.
// ----------------------------------------------------------------------------
module mfep_back (
  input  logic                clk,
  input  logic                rst,
  input  mfep_pkg::item_t     item,
  input  logic                item_valid,
  output logic                item_take,
  output mfep_pkg::result_t   res,
  output logic                res_valid,
  input  logic                res_stall
);

  mfep_pkg::phase_t  phase, phase_next;
  logic [3:0]   byte_counter, byte_counter_next;
  logic [31:0]  assembly_word, assembly_word_next;
  logic [7:0]   running_status, running_status_next;
  logic [7:0]   event_status, event_status_next;
  logic [7:0]   first_data, first_data_next;
  logic [34:0]  delta_acc, delta_acc_next;
  logic [2:0]   quantity_bytes, quantity_bytes_next;
  logic [39:0]  track_position, track_position_next;
  logic [31:0]  track_bytes_left, track_bytes_left_next;
  logic [34:0]  payload_left, payload_left_next;
  logic [15:0]  tracks_total, tracks_total_next;
  logic [15:0]  tracks_done, tracks_done_next;
  logic         held_format, held_format_next;
  logic [15:0]  held_division, held_division_next;
  logic [7:0]   held_meta_type, held_meta_type_next;
  logic [2:0]   magic_bad, magic_bad_next;

  logic               emit;
  mfep_pkg::result_t  r;
  logic               fire;
  logic [7:0]         b;

  assign item_take = item_valid && (!res_valid || !res_stall);
  assign fire      = item_take;
  assign b         = item.data;

  always_comb begin
    logic        ended;
    logic [34:0] acc;
    logic [34:0] vsum;
    logic [2:0]  qn;
    logic [31:0] aw;
    logic [7:0]  s;
    logic        do_first;
    logic        do_len;
    logic [15:0] d1;
    logic [15:0] dv;
    phase_next            = phase;
    byte_counter_next     = byte_counter;
    assembly_word_next    = assembly_word;
    running_status_next   = running_status;
    event_status_next     = event_status;
    first_data_next       = first_data;
    delta_acc_next        = delta_acc;
    quantity_bytes_next   = quantity_bytes;
    track_position_next   = track_position;
    track_bytes_left_next = track_bytes_left;
    payload_left_next     = payload_left;
    tracks_total_next     = tracks_total;
    tracks_done_next      = tracks_done;
    held_format_next      = held_format;
    held_division_next    = held_division;
    held_meta_type_next   = held_meta_type;
    magic_bad_next        = magic_bad;
    emit     = 1'b0;
    r        = '0;
    ended    = 1'b0;
    acc      = '0;
    vsum     = '0;
    qn       = quantity_bytes + 3'd1;
    aw       = {assembly_word[23:0], b};
    s        = event_status;
    do_first = 1'b0;
    do_len   = 1'b0;
    d1       = '0;
    dv       = '0;

    unique case (phase)
      mfep_pkg::PH_HDR: begin
        if (byte_counter < 4'd4 && b != mfep_pkg::hdr_magic(byte_counter[1:0])
            && magic_bad == 3'd0)
          magic_bad_next = mfep_pkg::ERR_HDR_MAG;
        assembly_word_next = aw;
        if (byte_counter == 4'd7 && aw != 32'd6 && magic_bad_next == 3'd0)
          magic_bad_next = mfep_pkg::ERR_HDR_LEN;
        if (byte_counter == 4'd9) begin
          if (aw[15:0] > 16'd1 && magic_bad_next == 3'd0)
            magic_bad_next = mfep_pkg::ERR_FORMAT;
          held_format_next = aw[0];
        end
        if (byte_counter == 4'd11) tracks_total_next = aw[15:0];
        if (byte_counter == 4'd13) begin
          if (magic_bad_next != 3'd0) begin
            held_format_next   = 1'b0;
            held_division_next = '0;
            emit         = 1'b1;
            r.kind       = mfep_pkg::KIND_ERROR;
            r.error_code = magic_bad_next;
            phase_next   = mfep_pkg::PH_ERR;
          end else begin
            // Negative division is frames per second times subframes.
            d1 = {8'hff, aw[15:8]};
            dv = aw[15] ? 16'(d1 * {8'd0, aw[7:0]}) : aw[15:0];
            held_division_next = dv;
            if (!held_format_next) tracks_total_next = 16'd1;
            emit       = 1'b1;
            r.kind     = mfep_pkg::KIND_HEADER;
            r.length   = {19'd0, tracks_total_next};
            tracks_done_next  = '0;
            byte_counter_next = '0;
            magic_bad_next    = '0;
            phase_next = (tracks_total_next == 16'd0) ? mfep_pkg::PH_DONE
                                                      : mfep_pkg::PH_TRK;
          end
        end else begin
          byte_counter_next = byte_counter + 4'd1;
        end
      end

      mfep_pkg::PH_TRK: begin
        if (byte_counter < 4'd4 && b != mfep_pkg::trk_magic(byte_counter[1:0]))
          magic_bad_next = 3'd1;
        if (byte_counter == 4'd3 && magic_bad_next != 3'd0) begin
          emit         = 1'b1;
          r.kind       = mfep_pkg::KIND_ERROR;
          r.error_code = mfep_pkg::ERR_TRK_MAG;
          phase_next   = mfep_pkg::PH_ERR;
        end else begin
          assembly_word_next = aw;
          if (byte_counter == 4'd7) begin
            track_bytes_left_next = aw;
            track_position_next   = '0;
            running_status_next   = '0;
            if (aw == 32'd0) begin
              emit   = 1'b1;
              r.kind = mfep_pkg::KIND_EOT;
              ended  = 1'b1;
            end else begin
              phase_next          = mfep_pkg::PH_DELTA;
              delta_acc_next      = '0;
              quantity_bytes_next = '0;
            end
          end else begin
            byte_counter_next = byte_counter + 4'd1;
          end
        end
      end

      mfep_pkg::PH_DELTA: begin
        vsum = delta_acc + {28'd0, b[6:0]};
        acc  = b[7] ? {vsum[27:0], 7'd0} : vsum;
        delta_acc_next      = acc;
        quantity_bytes_next = qn;
        if (!b[7] || qn >= 3'(mfep_pkg::VLQ_MAX_BYTES)) begin
          track_position_next = track_position + {5'd0, acc};
          phase_next          = mfep_pkg::PH_STATUS;
        end
      end

      mfep_pkg::PH_STATUS: begin
        if (item.is_status) begin
          event_status_next   = b;
          running_status_next = item.is_system ? 8'd0 : b;
          phase_next          = mfep_pkg::PH_FIRST;
        end else begin
          event_status_next = running_status;
          s                 = running_status;
          do_first          = 1'b1;
        end
      end

      mfep_pkg::PH_FIRST: do_first = 1'b1;

      mfep_pkg::PH_DATA2: begin
        emit    = 1'b1;
        r.kind  = mfep_pkg::KIND_CHANNEL;
        r.delta = delta_acc;
        r.status = event_status;
        r.data1 = first_data;
        r.data2 = b;
        phase_next          = mfep_pkg::PH_DELTA;
        delta_acc_next      = '0;
        quantity_bytes_next = '0;
      end

      mfep_pkg::PH_LEN: do_len = 1'b1;

      mfep_pkg::PH_SKIP: begin
        payload_left_next = payload_left - 35'd1;
        if (payload_left_next == '0) begin
          phase_next          = mfep_pkg::PH_DELTA;
          delta_acc_next      = '0;
          quantity_bytes_next = '0;
        end
      end

      default: ;
    endcase

    if (do_first) begin
      if ((s >= 8'h80 && s <= 8'hbf) || (s >= 8'he0 && s <= 8'hef)) begin
        first_data_next = b;
        phase_next      = mfep_pkg::PH_DATA2;
      end else if (s >= 8'hc0 && s <= 8'hdf) begin
        emit     = 1'b1;
        r.kind   = mfep_pkg::KIND_CHANNEL;
        r.delta  = delta_acc;
        r.status = s;
        r.data1  = b;
        phase_next          = mfep_pkg::PH_DELTA;
        delta_acc_next      = '0;
        quantity_bytes_next = '0;
      end else if (s == 8'hf0 || s == 8'hf7) begin
        phase_next = mfep_pkg::PH_LEN;
        do_len     = 1'b1;
      end else if (s == 8'hff) begin
        held_meta_type_next = b;
        payload_left_next   = '0;
        quantity_bytes_next = '0;
        phase_next          = mfep_pkg::PH_LEN;
      end else begin
        phase_next          = mfep_pkg::PH_DELTA;
        delta_acc_next      = '0;
        quantity_bytes_next = '0;
      end
    end

    if (do_len) begin
      // Sysex length starts fresh when entered straight from the status byte.
      qn   = (phase == mfep_pkg::PH_LEN) ? quantity_bytes + 3'd1 : 3'd1;
      vsum = ((phase == mfep_pkg::PH_LEN) ? payload_left : 35'd0) + {28'd0, b[6:0]};
      acc  = b[7] ? {vsum[27:0], 7'd0} : vsum;
      payload_left_next   = acc;
      quantity_bytes_next = qn;
      if (!b[7] || qn >= 3'(mfep_pkg::VLQ_MAX_BYTES)) begin
        emit    = 1'b1;
        r.delta = delta_acc;
        r.length = acc;
        if (s == 8'hff && held_meta_type == 8'h2f) begin
          r.kind      = mfep_pkg::KIND_EOT;
          r.status    = 8'hff;
          r.meta_type = 8'h2f;
          ended       = 1'b1;
        end else begin
          if (s == 8'hff) begin
            r.kind      = mfep_pkg::KIND_META;
            r.status    = 8'hff;
            r.meta_type = held_meta_type;
          end else begin
            r.kind   = mfep_pkg::KIND_SYSEX;
            r.status = s;
          end
          if (acc != '0) begin
            phase_next = mfep_pkg::PH_SKIP;
          end else begin
            phase_next          = mfep_pkg::PH_DELTA;
            delta_acc_next      = '0;
            quantity_bytes_next = '0;
          end
        end
      end
    end

    if (!ended && phase != mfep_pkg::PH_HDR && phase != mfep_pkg::PH_TRK
        && phase != mfep_pkg::PH_DONE && phase != mfep_pkg::PH_ERR) begin
      track_bytes_left_next = track_bytes_left - 32'd1;
      if (track_bytes_left_next == '0) begin
        if (!emit) begin
          emit   = 1'b1;
          r      = '0;
          r.kind = mfep_pkg::KIND_EOT;
        end
        ended = 1'b1;
      end
    end

    // Result fields use the track index and position before the track closes.
    r.track    = tracks_done;
    r.position = track_position_next;
    r.division = held_division_next;
    r.format   = held_format_next;
    if (r.kind == mfep_pkg::KIND_EOT && phase == mfep_pkg::PH_TRK)
      r.position = '0;

    if (ended) begin
      tracks_done_next    = tracks_done + 16'd1;
      track_position_next = '0;
      delta_acc_next      = '0;
      byte_counter_next   = '0;
      magic_bad_next      = '0;
      phase_next = (tracks_done_next == tracks_total_next) ? mfep_pkg::PH_DONE
                                                           : mfep_pkg::PH_TRK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= mfep_pkg::PH_HDR;
      byte_counter     <= '0;
      assembly_word    <= '0;
      running_status   <= '0;
      event_status     <= '0;
      first_data       <= '0;
      delta_acc        <= '0;
      quantity_bytes   <= '0;
      track_position   <= '0;
      track_bytes_left <= '0;
      payload_left     <= '0;
      tracks_total     <= '0;
      tracks_done      <= '0;
      held_format      <= 1'b0;
      held_division    <= '0;
      held_meta_type   <= '0;
      magic_bad        <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (fire) begin
        phase            <= phase_next;
        byte_counter     <= byte_counter_next;
        assembly_word    <= assembly_word_next;
        running_status   <= running_status_next;
        event_status     <= event_status_next;
        first_data       <= first_data_next;
        delta_acc        <= delta_acc_next;
        quantity_bytes   <= quantity_bytes_next;
        track_position   <= track_position_next;
        track_bytes_left <= track_bytes_left_next;
        payload_left     <= payload_left_next;
        tracks_total     <= tracks_total_next;
        tracks_done      <= tracks_done_next;
        held_format      <= held_format_next;
        held_division    <= held_division_next;
        held_meta_type   <= held_meta_type_next;
        magic_bad        <= magic_bad_next;
      end
      if (fire) res_valid <= emit;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) res <= r;
  end

endmodule

[hw/rtl/midi_file_event_parser.sv]
// ----------------------------------------------------------------------------
// midi_file_event_parser
// Byte-serial Standard MIDI File parser: checks the header and track chunks
// and reports decoded events.
// ----------------------------------------------------------------------------
//   channel | signals                         | direction
//   input   | valid, stall, byte_in           | file bytes in
//   output  | out_valid, out_stall, kind ...  | decoded results out
//
// One byte per cycle is sustained while the output does not stall; each byte
// passes a four-entry queue and then the parse state machine, whose result
// register feeds the output. A byte waits in the queue, its result in the
// result register. Reset clears all parse state. A stall on the output holds
// the parser; the queue keeps accepting until full.
module midi_file_event_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [2:0]  error_code,
  output logic [15:0] track,
  output logic [34:0] delta,
  output logic [39:0] position,
  output logic [7:0]  status,
  output logic [7:0]  data1,
  output logic [7:0]  data2,
  output logic [7:0]  meta_type,
  output logic [34:0] length,
  output logic signed [15:0] division,
  output logic        format
);

  mfep_pkg::item_t   item;
  logic              item_valid;
  logic              item_take;
  mfep_pkg::result_t res;

  mfep_front u_front (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .byte_in(byte_in),
    .item(item), .item_valid(item_valid), .item_take(item_take)
  );

  mfep_back u_back (
    .clk(clk), .rst(rst), .item(item), .item_valid(item_valid),
    .item_take(item_take), .res(res), .res_valid(out_valid),
    .res_stall(out_stall)
  );

  assign kind       = res.kind;
  assign error_code = res.error_code;
  assign track      = res.track;
  assign delta      = res.delta;
  assign position   = res.position;
  assign status     = res.status;
  assign data1      = res.data1;
  assign data2      = res.data2;
  assign meta_type  = res.meta_type;
  assign length     = res.length;
  assign division   = res.division;
  assign format     = res.format;

endmodule

[bench/midi_event_checker.sv]
// ----------------------------------------------------------------------------
// midi_event_checker
// Watches both channels of the MIDI file event parser. It predicts the
// decoded results of the accepted file bytes and compares each result, field
// by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_event_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        stall,
  input  logic [7:0]  byte_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  kind,
  input  logic [2:0]  error_code,
  input  logic [15:0] track,
  input  logic [34:0] delta,
  input  logic [39:0] position,
  input  logic [7:0]  status,
  input  logic [7:0]  data1,
  input  logic [7:0]  data2,
  input  logic [7:0]  meta_type,
  input  logic [34:0] length,
  input  logic [15:0] division,
  input  logic        format,
  output int          fails,
  output int          pending
);

  localparam logic [31:0] HDR_TAG = 32'h4d546864;
  localparam logic [31:0] TRK_TAG = 32'h4d54726b;

  // Parse state of the predictor.
  mfep_pkg::phase_t ph;
  logic [3:0]  cnt;
  logic [31:0] word;
  logic [7:0]  run_st, ev_st, first_b, meta_held;
  logic [34:0] dacc, plen;
  logic [2:0]  qb;
  logic [39:0] tpos;
  logic [31:0] tleft;
  logic [15:0] ntracks, tdone;
  logic        fmt;
  logic [15:0] div;
  logic [2:0]  bad;

  mfep_pkg::result_t event_q[$];
  int      nfail;

  function automatic void clear_parse();
    ph = mfep_pkg::PH_HDR; cnt = '0; word = '0; run_st = '0; ev_st = '0; first_b = '0;
    meta_held = '0; dacc = '0; plen = '0; qb = '0; tpos = '0; tleft = '0;
    ntracks = '0; tdone = '0; fmt = 1'b0; div = '0; bad = '0;
  endfunction

  function automatic mfep_pkg::result_t mk(logic [2:0] k, logic [2:0] e, logic [34:0] dl,
                                           logic [7:0] st, logic [7:0] a, logic [7:0] b,
                                           logic [7:0] mt, logic [34:0] ln);
    mfep_pkg::result_t r;
    r.kind = k; r.error_code = e; r.track = tdone; r.delta = dl;
    r.position = tpos; r.status = st; r.data1 = a; r.data2 = b;
    r.meta_type = mt; r.length = ln; r.division = div; r.format = fmt;
    return r;
  endfunction

  // Adds one byte of a variable-length quantity; true when it is complete.
  function automatic bit vlq_add(inout logic [34:0] acc, input logic [7:0] b);
    acc = acc + 35'(b[6:0]);
    if (b[7]) acc = acc << 7;
    qb = qb + 3'd1;
    return !b[7] || (int'(qb) >= mfep_pkg::VLQ_MAX_BYTES);
  endfunction

  function automatic void start_event();
    ph = mfep_pkg::PH_DELTA; dacc = '0; qb = '0;
  endfunction

  function automatic void close_track();
    tdone = tdone + 16'd1;
    tpos = '0; dacc = '0; cnt = '0; bad = '0;
    ph = (tdone == ntracks) ? mfep_pkg::PH_DONE : mfep_pkg::PH_TRK;
  endfunction

  function automatic bit length_byte(logic [7:0] b, output mfep_pkg::result_t r,
                                     inout bit ended);
    if (!vlq_add(plen, b)) return 1'b0;
    if (ev_st == 8'hff && meta_held == 8'h2f) begin
      r = mk(mfep_pkg::KIND_EOT, mfep_pkg::ERR_NONE, dacc, 8'hff, 8'h00, 8'h00, 8'h2f,
             plen);
      close_track();
      ended = 1'b1;
      return 1'b1;
    end
    if (ev_st == 8'hff)
      r = mk(mfep_pkg::KIND_META, mfep_pkg::ERR_NONE, dacc, 8'hff, 8'h00, 8'h00,
             meta_held, plen);
    else
      r = mk(mfep_pkg::KIND_SYSEX, mfep_pkg::ERR_NONE, dacc, ev_st, 8'h00, 8'h00, 8'h00,
             plen);
    if (plen != 0) ph = mfep_pkg::PH_SKIP;
    else start_event();
    return 1'b1;
  endfunction

  // First byte after an explicit or running status.
  function automatic bit after_status(logic [7:0] b, output mfep_pkg::result_t r,
                                      inout bit ended);
    if ((ev_st >= 8'h80 && ev_st <= 8'hbf) || (ev_st >= 8'he0 && ev_st <= 8'hef)) begin
      first_b = b;
      ph = mfep_pkg::PH_DATA2;
      return 1'b0;
    end
    if (ev_st >= 8'hc0 && ev_st <= 8'hdf) begin
      r = mk(mfep_pkg::KIND_CHANNEL, mfep_pkg::ERR_NONE, dacc, ev_st, b, 8'h00, 8'h00, '0);
      start_event();
      return 1'b1;
    end
    if (ev_st == 8'hf0 || ev_st == 8'hf7) begin
      plen = '0; qb = '0; ph = mfep_pkg::PH_LEN;
      return length_byte(b, r, ended);
    end
    if (ev_st == 8'hff) begin
      meta_held = b; plen = '0; qb = '0; ph = mfep_pkg::PH_LEN;
      return 1'b0;
    end
    start_event();
    return 1'b0;
  endfunction

  function automatic bit parse_byte(logic [7:0] b, output mfep_pkg::result_t r);
    bit ended, got;
    int d1, d2, dv;
    ended = 1'b0;
    got = 1'b0;
    r = '0;
    case (ph)
      mfep_pkg::PH_HDR: begin
        if (cnt < 4 && b != HDR_TAG[31 - 8 * cnt -: 8] && bad == 0)
          bad = mfep_pkg::ERR_HDR_MAG;
        word = {word[23:0], b};
        if (cnt == 7 && word != 32'd6 && bad == 0) bad = mfep_pkg::ERR_HDR_LEN;
        if (cnt == 9) begin
          if (word[15:0] > 16'd1 && bad == 0) bad = mfep_pkg::ERR_FORMAT;
          fmt = word[0];
        end
        if (cnt == 11) ntracks = word[15:0];
        if (cnt == 13) begin
          if (bad != 0) begin
            fmt = 1'b0; div = '0;
            r = mk(mfep_pkg::KIND_ERROR, bad, '0, 8'h00, 8'h00, 8'h00, 8'h00, '0);
            ph = mfep_pkg::PH_ERR;
            return 1'b1;
          end
          d1 = int'(word[15:8]);
          d2 = int'(word[7:0]);
          dv = (d1 < 128) ? d1 * 256 + d2 : (d1 - 256) * d2;
          div = dv[15:0];
          if (fmt == 1'b0) ntracks = 16'd1;
          r = mk(mfep_pkg::KIND_HEADER, mfep_pkg::ERR_NONE, '0, 8'h00, 8'h00, 8'h00, 8'h00,
                 35'(ntracks));
          tdone = '0; cnt = '0; bad = '0;
          ph = (ntracks == 0) ? mfep_pkg::PH_DONE : mfep_pkg::PH_TRK;
          return 1'b1;
        end
        cnt = cnt + 4'd1;
        return 1'b0;
      end
      mfep_pkg::PH_TRK: begin
        if (cnt < 4 && b != TRK_TAG[31 - 8 * cnt -: 8]) bad = 3'd1;
        if (cnt == 3 && bad != 0) begin
          r = mk(mfep_pkg::KIND_ERROR, mfep_pkg::ERR_TRK_MAG, '0, 8'h00, 8'h00, 8'h00,
                 8'h00, '0);
          ph = mfep_pkg::PH_ERR;
          return 1'b1;
        end
        word = {word[23:0], b};
        if (cnt == 7) begin
          tleft = word; tpos = '0; run_st = '0;
          if (tleft == 0) begin
            r = mk(mfep_pkg::KIND_EOT, mfep_pkg::ERR_NONE, '0, 8'h00, 8'h00, 8'h00, 8'h00,
                   '0);
            close_track();
            return 1'b1;
          end
          start_event();
          return 1'b0;
        end
        cnt = cnt + 4'd1;
        return 1'b0;
      end
      mfep_pkg::PH_DELTA: begin
        if (vlq_add(dacc, b)) begin
          tpos = tpos + 40'(dacc);
          ph = mfep_pkg::PH_STATUS;
        end
      end
      mfep_pkg::PH_STATUS: begin
        if (b[7]) begin
          ev_st = b;
          run_st = (b < 8'hf0) ? b : 8'h00;
          ph = mfep_pkg::PH_FIRST;
        end else begin
          ev_st = run_st;
          got = after_status(b, r, ended);
        end
      end
      mfep_pkg::PH_FIRST: got = after_status(b, r, ended);
      mfep_pkg::PH_DATA2: begin
        r = mk(mfep_pkg::KIND_CHANNEL, mfep_pkg::ERR_NONE, dacc, ev_st, first_b, b, 8'h00,
               '0);
        start_event();
        got = 1'b1;
      end
      mfep_pkg::PH_LEN: got = length_byte(b, r, ended);
      mfep_pkg::PH_SKIP: begin
        plen = plen - 35'd1;
        if (plen == 0) start_event();
      end
      default: return 1'b0;
    endcase
    // The declared track length ends the track even in the middle of an event.
    if (!ended) begin
      tleft = tleft - 32'd1;
      if (tleft == 0) begin
        if (!got) begin
          r = mk(mfep_pkg::KIND_EOT, mfep_pkg::ERR_NONE, '0, 8'h00, 8'h00, 8'h00, 8'h00,
                 '0);
          got = 1'b1;
        end
        close_track();
      end
    end
    return got;
  endfunction

  function automatic void check_field(string name, logic [39:0] exp_v, logic [39:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      nfail++;
    end
  endfunction

  always @(posedge clk) begin
    mfep_pkg::result_t e;
    mfep_pkg::result_t p;
    if (rst) begin
      clear_parse();
      event_q.delete();
      nfail = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (event_q.size() == 0) begin
          $display("%0t: result with nothing expected, kind %0d", $time, kind);
          nfail++;
        end else begin
          e = event_q.pop_front();
          check_field("kind", 40'(e.kind), 40'(kind));
          check_field("error_code", 40'(e.error_code), 40'(error_code));
          check_field("track", 40'(e.track), 40'(track));
          check_field("delta", 40'(e.delta), 40'(delta));
          check_field("position", e.position, position);
          check_field("status", 40'(e.status), 40'(status));
          check_field("data1", 40'(e.data1), 40'(data1));
          check_field("data2", 40'(e.data2), 40'(data2));
          check_field("meta_type", 40'(e.meta_type), 40'(meta_type));
          check_field("length", 40'(e.length), 40'(length));
          check_field("division", 40'(e.division), 40'(division));
          check_field("format", 40'(e.format), 40'(format));
        end
      end
      if (valid && !stall) begin
        if (parse_byte(byte_in, p)) event_q.push_back(p);
      end
    end
    fails   <= nfail;
    pending <= event_q.size();
  end

endmodule

[bench/tb_midi_file_event_parser.sv]
// ----------------------------------------------------------------------------
// tb_midi_file_event_parser
// Feeds one long MIDI file to the parser: a directed track first, then random
// tracks with every event type, truncated and zero-length tracks, and finally
// a chunk with a bad tag. Both channels idle at random; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_midi_file_event_parser;

  localparam int BYTE_TARGET = 664;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TRACK_COUNT = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind, error_code;
  logic [15:0] track;
  logic [34:0] delta, length;
  logic [39:0] position;
  logic [7:0]  status, data1, data2, meta_type;
  logic signed [15:0] division;
  logic        format;
  int          fails, pending;

  int          bytes_sent = 0;
  int          idle_cycles = 0;
  int          sink_wait = 0;
  bit          send_busy = 1'b0;
  bit          sink_busy = 1'b0;
  logic [7:0]  body[$];
  logic [7:0]  gen_rs;

  always #6 clk = ~clk;

  midi_file_event_parser DUT (.*);

  midi_event_checker u_checker (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .byte_in(byte_in),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .error_code(error_code), .track(track), .delta(delta), .position(position),
    .status(status), .data1(data1), .data2(data2), .meta_type(meta_type),
    .length(length), .division(division), .format(format),
    .fails(fails), .pending(pending)
  );

  // Output back-pressure: a fresh stall length is drawn after every result, none while sink_busy is set.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sink_wait = sink_busy ? 0 : $urandom_range(0, 18);
      out_stall <= (sink_wait != 0);
    end else if (sink_wait > 0) begin
      sink_wait--;
      out_stall <= (sink_wait != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (valid && !stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL midi_file_event_parser");
      $finish;
    end
  end

  task automatic put_byte(logic [7:0] b);
    int gap;
    gap = send_busy ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid   <= 1'b1;
    byte_in <= b;
    @(posedge clk);
    while (stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic put_list(logic [7:0] q[$]);
    foreach (q[i]) put_byte(q[i]);
  endtask

  // Let every result come out before the next transaction is offered.
  task automatic drain();
    valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_chunk_head(logic [31:0] len);
    put_list('{8'h4d, 8'h54, 8'h72, 8'h6b, len[31:24], len[23:16], len[15:8], len[7:0]});
  endtask

  function automatic void add_vlq(int unsigned v);
    logic [7:0] tmp[$];
    tmp.push_front(8'(v & 32'h7f));
    v = v >> 7;
    while (v != 0) begin
      tmp.push_front(8'h80 | 8'(v & 32'h7f));
      v = v >> 7;
    end
    foreach (tmp[i]) body.push_back(tmp[i]);
  endfunction

  function automatic void add_delta();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel < 4) body.push_back(8'($urandom_range(0, 127)));
    else if (sel < 6) add_vlq($urandom_range(128, 32'h1fffff));
    else if (sel == 6) add_vlq($urandom_range(32'h200000, 32'h0fffffff));
    else begin
      // Over-long quantity: four bytes that all ask for more.
      repeat (4) body.push_back(8'h80 | 8'($urandom_range(0, 127)));
    end
  endfunction

  function automatic void add_data(logic [7:0] st);
    body.push_back(8'($urandom_range(0, 127)));
    if (!(st >= 8'hc0 && st <= 8'hdf)) body.push_back(8'($urandom_range(0, 127)));
  endfunction

  function automatic void add_event();
    int sel, n;
    logic [7:0] st;
    add_delta();
    sel = $urandom_range(0, 15);
    if (sel < 6 || sel > 13) begin
      st = 8'($urandom_range(8'h80, 8'hef));
      gen_rs = st;
      body.push_back(st);
      add_data(st);
    end else if (sel < 9) begin
      if (gen_rs == 0) body.push_back(8'($urandom_range(0, 127)));
      else add_data(gen_rs);
    end else if (sel == 9) begin
      gen_rs = 8'h00;
      body.push_back($urandom_range(0, 1) ? 8'hf0 : 8'hf7);
      n = $urandom_range(0, 4);
      add_vlq(n);
      repeat (n) body.push_back(8'($urandom));
    end else if (sel < 12) begin
      gen_rs = 8'h00;
      body.push_back(8'hff);
      st = 8'($urandom);
      if (st == 8'h2f) st = 8'h51;
      body.push_back(st);
      n = $urandom_range(0, 4);
      add_vlq(n);
      repeat (n) body.push_back(8'($urandom));
    end else if (sel == 12) begin
      gen_rs = 8'h00;
      st = 8'($urandom_range(8'hf1, 8'hfe));
      if (st == 8'hf7) st = 8'hf6;
      body.push_back(st);
      body.push_back(8'($urandom));
    end else begin
      body.push_back(8'($urandom_range(0, 127)));
    end
  endfunction

  // Builds and sends one random track with a random kind of ending.
  task automatic put_random_track();
    int mode, n;
    bit has_end;
    logic [31:0] len;
    body.delete();
    gen_rs = 8'h00;
    n = $urandom_range(2, 12);
    repeat (n) add_event();
    has_end = ($urandom_range(0, 3) != 0);
    if (has_end) begin
      body.push_back(8'($urandom_range(0, 127)));
      body.push_back(8'hff);
      body.push_back(8'h2f);
      body.push_back(8'($urandom_range(0, 3)));
    end
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      len = body.size();
      if (has_end && mode > 3) len = len + ((mode == 5) ? 32'hfff00000 : $urandom_range(1, 40));
    end else if (mode < 9) begin
      len = $urandom_range(1, body.size() - 1);
      body = body[0:len - 1];
    end else begin
      len = 0;
      body.delete();
    end
    put_chunk_head(len);
    put_list(body);
  endtask

  initial begin
    logic [7:0] d1, d2;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Format 1 header with a random division.
    d1 = 8'($urandom);
    d2 = 8'($urandom);
    put_list('{8'h4d, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
               8'h00, 8'h01, 8'h00, 8'(TRACK_COUNT), d1, d2});
    drain();

    // Directed track: stray data byte, note events with running status,
    // program change, sysex of both kinds, long and over-long delta times,
    // a system byte, a tempo meta and the end-of-track meta.
    body = '{8'h00, 8'h3c, 8'h00, 8'h90, 8'h3c, 8'h40, 8'h05, 8'h3c, 8'h00,
             8'h81, 8'h00, 8'hc0, 8'h05, 8'h00, 8'hf0, 8'h02, 8'h11, 8'h22,
             8'h00, 8'hf7, 8'h00, 8'hff, 8'hff, 8'hff, 8'h7f, 8'hff, 8'h03,
             8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'he0, 8'h00, 8'h40, 8'h00,
             8'hf2, 8'h55, 8'h00, 8'hff, 8'h51, 8'h03, 8'h07, 8'ha1, 8'h20,
             8'h00, 8'hff, 8'h2f, 8'h00};
    put_chunk_head(body.size());
    put_list(body);
    // An empty track, then one cut short after a note event, inside the next delta time.
    put_chunk_head(32'd0);
    put_chunk_head(32'd5);
    put_list('{8'h00, 8'h90, 8'h3c, 8'h40, 8'h00});
    drain();

    for (int t = 3; t < TRACK_COUNT - 1 && bytes_sent < BYTE_TARGET; t++) begin
      send_busy = ($urandom_range(0, 3) == 0);
      sink_busy = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) drain();
      put_random_track();
    end
    send_busy = 1'b0;
    sink_busy = 1'b0;

    // A chunk with a bad tag latches the error; later bytes are ignored.
    put_list('{8'h4d, 8'h54, 8'h72, 8'h58});
    repeat (8) put_byte(8'($urandom));
    valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fails == 0) $display("PASS midi_file_event_parser");
    else $display("FAIL midi_file_event_parser");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mfep_pkg.sv
hw/rtl/mfep_front.sv
hw/rtl/mfep_back.sv
hw/rtl/midi_file_event_parser.sv
bench/midi_event_checker.sv
bench/tb_midi_file_event_parser.sv
